/* hdl/mf2d_pkg.sv */
// mf2d_pkg: shared types and constants of the 2-D median filter.
// Beat payloads, sorter cell type, register indexes.
// No dependencies.
package mf2d_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int OUT_COL_BITS = 10;
   localparam int ROW_BITS     = 12;
   localparam int CFG_W_BITS   = 11;
   localparam int CFG_H_BITS   = 12;
   localparam int CFG_R_BITS   = 2;
   localparam int EFF_W_BITS   = 13;
   localparam int RUN_BITS     = 3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_DRAIN  = 1'b1;

   localparam logic [RUN_BITS-1:0] RUN_MAX   = 3'd4;
   localparam logic [RUN_BITS-1:0] RUN_DRAIN = 3'd1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic       func;
      sample_type sample;
   } req_type;

   typedef struct packed {
      sample_type                median_value;
      logic [OUT_COL_BITS-1:0]   out_col;
      logic [ROW_BITS-1:0]       out_row;
      logic                      last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      sample_type value;
   } cell_type;

endpackage

/* hdl/mf2d_cell.sv */
// mf2d_cell: one cell of the insertion sorter chain.
// Holds one sorted value; empty cells act as +infinity. Uses mf2d_pkg.
module mf2d_cell import mf2d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       ins,
   input  sample_type x,
   input  cell_type   prev,
   input  logic       prev_gt,
   output cell_type   cur,
   output logic       gt
);

   cell_type cell_ff;
   cell_type cell_in;

   assign gt  = !cell_ff.valid || (cell_ff.value > x);
   assign cur = cell_ff;

   always_comb begin
      cell_in = cell_ff;
      if (clear) begin
         cell_in.valid = 1'b0;
      end else if (ins && gt) begin
         if (prev_gt) begin
            cell_in = prev;
         end else begin
            cell_in.valid = 1'b1;
            cell_in.value = x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
         cell_ff.value <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

endmodule

/* hdl/mf2d_sorter.sv */
// mf2d_sorter: chain of mf2d_cell keeping window samples in ascending order.
// One insertion per beat of x; selected rank read out. Uses mf2d_pkg, mf2d_cell.
module mf2d_sorter import mf2d_pkg::*; #(
   parameter int DEPTH = 49
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     ins,
   input  sample_type               x,
   input  logic [$clog2(DEPTH)-1:0] sel,
   output sample_type               sel_value
);

   cell_type cells [DEPTH];
   logic     gts   [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         mf2d_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .ins     (ins),
            .x       (x),
            .prev    ('0),
            .prev_gt (1'b0),
            .cur     (cells[i]),
            .gt      (gts[i])
         );
      end else begin : g_body
         mf2d_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .ins     (ins),
            .x       (x),
            .prev    (cells[i-1]),
            .prev_gt (gts[i-1]),
            .cur     (cells[i]),
            .gt      (gts[i])
         );
      end
   end

   assign sel_value = cells[sel].value;

endmodule

/* hdl/median_filter_2d_top.sv */
// median_filter_2d_top: streaming 2-D median filter, APB register port.
// Uses mf2d_pkg, mf2d_sorter (chain of mf2d_cell), a row store memory.
//
// Pixels arrive in raster order; each result is the median of the in-image samples
// in a (2r+1)x(2r+1) window, upper median for even counts, sent in raster order once
// its window is complete. A drain beat flushes one pending result at frame end. One
// input beat is taken, then the block is busy: it does its bookkeeping, and per
// result steps the window through the row store (one read per cycle) into the
// sorter chain, then holds the result on the result port until it is taken.
// A sample beat yields up to 4 results, a drain beat up to 1.
module median_filter_2d_top import mf2d_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ROWS = 2 * MAX_RADIUS + 1;
   localparam int WIN  = ROWS * ROWS;
   localparam int COLW = $clog2(MAX_WIDTH);
   localparam int AW   = $clog2(ROWS * MAX_WIDTH);
   localparam int SLW  = $clog2(ROWS);
   localparam int TW   = $clog2(3 * ROWS);
   localparam int NW   = $clog2(WIN + 1);
   localparam int SELW = $clog2(WIN);
   localparam int KW   = $clog2(ROWS);
   localparam int LW   = ROW_BITS + EFF_W_BITS + 1;

   localparam logic [EFF_W_BITS-1:0] MAXW_V = EFF_W_BITS'(MAX_WIDTH);
   localparam logic [1:0]            MAXR_V = 2'(MAX_RADIUS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;
   localparam logic [2:0] ST_WIN  = 3'd2;
   localparam logic [2:0] ST_FL   = 3'd3;
   localparam logic [2:0] ST_MED  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [CFG_W_BITS-1:0] cfg_w_ff;
   logic [CFG_H_BITS-1:0] cfg_h_ff;
   logic [CFG_R_BITS-1:0] cfg_r_ff;

   logic [2:0]          state_ff;
   logic [COLW-1:0]     in_col_ff, res_col_ff;
   logic [ROW_BITS-1:0] in_row_ff, res_row_ff;
   logic [SLW-1:0]      in_slot_ff, res_slot_ff;
   logic                full_ff;
   logic [RUN_BITS-1:0] limit_ff, cnt_ff;
   logic                have_ff, last_ff;
   logic [KW-1:0]       ky_ff, kx_ff;
   logic                rd_valid_ff;
   sample_type          rd_data_ff;
   logic [NW-1:0]       n_ff;
   sample_type          med_ff;
   logic [COLW-1:0]     out_col_ff;
   logic [ROW_BITS-1:0] out_row_ff;

   sample_type mem [ROWS * MAX_WIDTH];

   // effective configuration
   logic [EFF_W_BITS-1:0] eff_w, w0;
   logic [ROW_BITS-1:0]   eff_h;
   logic [1:0]            eff_r;

   always_comb begin
      w0    = (cfg_w_ff == '0) ? EFF_W_BITS'(1) : EFF_W_BITS'(cfg_w_ff);
      eff_w = (w0 > MAXW_V) ? MAXW_V : w0;
      eff_h = (cfg_h_ff == '0) ? ROW_BITS'(1) : cfg_h_ff;
      eff_r = (cfg_r_ff > MAXR_V) ? MAXR_V : cfg_r_ff;
   end

   // head readiness: last window sample already in
   logic [ROW_BITS:0]     lr_sum;
   logic [ROW_BITS-1:0]   lr;
   logic [EFF_W_BITS-1:0] lc_sum, lc;
   logic [LW-1:0]         lin_in, lin_lr;
   logic                  head_ready, go;

   always_comb begin
      lr_sum = {1'b0, res_row_ff} + (ROW_BITS + 1)'(eff_r);
      lr     = (lr_sum > {1'b0, eff_h - 1'b1}) ? (eff_h - 1'b1) : lr_sum[ROW_BITS-1:0];
      lc_sum = EFF_W_BITS'(res_col_ff) + EFF_W_BITS'(eff_r);
      lc     = (lc_sum > eff_w - 1'b1) ? (eff_w - 1'b1) : lc_sum;
      lin_in = LW'(in_row_ff) * LW'(eff_w) + LW'(in_col_ff);
      lin_lr = LW'(lr) * LW'(eff_w) + LW'(lc);
      head_ready = full_ff || (lin_in > lin_lr);
      go = head_ready && (cnt_ff < limit_ff);
   end

   // window walk address generation
   logic [ROW_BITS:0]     y_off, y;
   logic [EFF_W_BITS-1:0] x_off, x;
   logic [TW-1:0]         s_raw, s_red;
   logic                  pos_ok, walk_end;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [2:0]            twor;

   always_comb begin
      twor   = {eff_r, 1'b0};
      y_off  = {1'b0, res_row_ff} + (ROW_BITS + 1)'(ky_ff);
      y      = y_off - (ROW_BITS + 1)'(eff_r);
      x_off  = EFF_W_BITS'(res_col_ff) + EFF_W_BITS'(kx_ff);
      x      = x_off - EFF_W_BITS'(eff_r);
      pos_ok = (y_off >= (ROW_BITS + 1)'(eff_r)) && (y < {1'b0, eff_h})
               && (x_off >= EFF_W_BITS'(eff_r)) && (x < eff_w);
      s_raw  = TW'(res_slot_ff) + TW'(ky_ff) + TW'(ROWS) - TW'(eff_r);
      if (s_raw >= TW'(2 * ROWS)) begin
         s_red = s_raw - TW'(2 * ROWS);
      end else if (s_raw >= TW'(ROWS)) begin
         s_red = s_raw - TW'(ROWS);
      end else begin
         s_red = s_raw;
      end
      rd_addr  = AW'(s_red) * AW'(MAX_WIDTH) + AW'(x[COLW-1:0]);
      wr_addr  = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
      walk_end = (kx_ff == KW'(twor)) && (ky_ff == KW'(twor));
   end

   // handshakes
   logic in_acc, wr_en, clr, out_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign in_acc    = req_valid && !req_stall;
   assign wr_en     = in_acc && (req_payload.func == FUNC_SAMPLE) && !full_ff
                      && (EFF_W_BITS'(in_col_ff) < MAXW_V);
   assign out_take  = (state_ff == ST_OUT) && !rsp_stall;
   assign clr       = ((state_ff == ST_CHK) && !have_ff && go) || (out_take && !last_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_payload.sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sorter chain
   sample_type    sel_value;
   logic [NW-1:0] half_n;

   assign half_n = n_ff >> 1;

   mf2d_sorter #(
      .DEPTH (WIN)
   ) u_sorter (
      .clock     (clock),
      .reset     (reset),
      .clear     (clr),
      .ins       (rd_valid_ff),
      .x         (rd_data_ff),
      .sel       (SELW'(half_n)),
      .sel_value (sel_value)
   );

   // control
   logic                  in_wrap_col, res_wrap_col;
   logic [EFF_W_BITS-1:0] in_col_nx, res_col_nx;

   assign in_col_nx    = EFF_W_BITS'(in_col_ff) + 1'b1;
   assign res_col_nx   = EFF_W_BITS'(res_col_ff) + 1'b1;
   assign in_wrap_col  = (in_col_nx >= eff_w);
   assign res_wrap_col = (res_col_nx >= eff_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         res_col_ff  <= '0;
         res_row_ff  <= '0;
         res_slot_ff <= '0;
         full_ff     <= 1'b0;
         limit_ff    <= RUN_MAX;
         cnt_ff      <= '0;
         have_ff     <= 1'b0;
         last_ff     <= 1'b0;
         ky_ff       <= '0;
         kx_ff       <= '0;
         rd_valid_ff <= 1'b0;
         n_ff        <= '0;
      end else begin
         rd_valid_ff <= (state_ff == ST_WIN) && pos_ok;
         if (rd_valid_ff) begin
            n_ff <= n_ff + 1'b1;
         end
         if (clr) begin
            n_ff  <= '0;
            ky_ff <= '0;
            kx_ff <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_acc) begin
                  cnt_ff   <= '0;
                  limit_ff <= (req_payload.func == FUNC_DRAIN) ? RUN_DRAIN : RUN_MAX;
                  if ((req_payload.func == FUNC_SAMPLE) && !full_ff) begin
                     if (in_wrap_col) begin
                        in_col_ff <= '0;
                        if (ROW_BITS'(in_row_ff + 1'b1) >= eff_h
                            || in_row_ff == '1) begin
                           in_row_ff  <= '0;
                           in_slot_ff <= '0;
                           full_ff    <= 1'b1;
                        end else begin
                           in_row_ff  <= in_row_ff + 1'b1;
                           in_slot_ff <= (in_slot_ff == SLW'(ROWS - 1)) ? '0
                                         : in_slot_ff + 1'b1;
                        end
                     end else begin
                        in_col_ff <= COLW'(in_col_nx);
                     end
                  end
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (have_ff) begin
                  last_ff  <= !go;
                  state_ff <= ST_OUT;
               end else if (go) begin
                  state_ff <= ST_WIN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WIN: begin
               if (walk_end) begin
                  state_ff <= ST_FL;
               end else if (kx_ff == KW'(twor)) begin
                  kx_ff <= '0;
                  ky_ff <= ky_ff + 1'b1;
               end else begin
                  kx_ff <= kx_ff + 1'b1;
               end
            end
            ST_FL: begin
               state_ff <= ST_MED;
            end
            ST_MED: begin
               cnt_ff  <= cnt_ff + 1'b1;
               have_ff <= 1'b1;
               if (res_wrap_col) begin
                  res_col_ff <= '0;
                  if (ROW_BITS'(res_row_ff + 1'b1) >= eff_h || res_row_ff == '1) begin
                     res_row_ff  <= '0;
                     res_slot_ff <= '0;
                     full_ff     <= 1'b0;
                  end else begin
                     res_row_ff  <= res_row_ff + 1'b1;
                     res_slot_ff <= (res_slot_ff == SLW'(ROWS - 1)) ? '0
                                    : res_slot_ff + 1'b1;
                  end
               end else begin
                  res_col_ff <= COLW'(res_col_nx);
               end
               state_ff <= ST_CHK;
            end
            ST_OUT: begin
               if (out_take) begin
                  have_ff  <= 1'b0;
                  state_ff <= last_ff ? ST_IDLE : ST_WIN;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MED) begin
         med_ff     <= (n_ff == '0) ? '0 : sel_value;
         out_col_ff <= res_col_ff;
         out_row_ff <= res_row_ff;
      end
   end

   assign rsp_valid                = (state_ff == ST_OUT);
   assign rsp_payload.median_value = med_ff;
   assign rsp_payload.out_col      = OUT_COL_BITS'(out_col_ff);
   assign rsp_payload.out_row      = out_row_ff;
   assign rsp_payload.last_of_run  = last_ff;

   // register port
   logic cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= CFG_W_BITS'(640);
         cfg_h_ff <= CFG_H_BITS'(480);
         cfg_r_ff <= CFG_R_BITS'(1);
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_WIDTH:  cfg_w_ff <= pwdata[CFG_W_BITS-1:0];
            REG_HEIGHT: cfg_h_ff <= pwdata[CFG_H_BITS-1:0];
            REG_RADIUS: cfg_r_ff <= pwdata[CFG_R_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = 32'(cfg_w_ff);
         REG_HEIGHT: prdata = 32'(cfg_h_ff);
         REG_RADIUS: prdata = 32'(cfg_r_ff);
         default:    prdata = '0;
      endcase
   end

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result shown while input open");

   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= limit_ff)
      else $error("too many results for one beat");

   a_have_state: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (state_ff == ST_CHK || state_ff == ST_OUT))
      else $error("held result outside check/output");

   a_chain_fill: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(WIN))
      else $error("sorter chain overfilled");

endmodule

/* sim/median_checker.sv */
// median_checker: watches the request, result and register ports of the 2-D median filter,
// predicts each result beat from its own frame store and compares in order.
// Depends on mf2d_pkg.
module median_checker import mf2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending,
   output logic        frame_open
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_ROWS = 7;
   localparam int MAX_W      = 1024;

   sample_type              rows [STORE_ROWS][MAX_W];
   int unsigned             col_in, row_in, col_out, row_out;
   bit                      full;
   logic [CFG_W_BITS-1:0]   cfg_w;
   logic [CFG_H_BITS-1:0]   cfg_h;
   logic [CFG_R_BITS-1:0]   cfg_r;
   rsp_type                 medians_q [$];

   function automatic int unsigned eff_width();
      int unsigned w;
      w = cfg_w;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_h == 0) ? 1 : cfg_h;
   endfunction

   function automatic bit window_complete();
      int unsigned lr, lc, w, h;
      w = eff_width();
      h = eff_height();
      if (full) return 1;
      lr = row_out + cfg_r;
      if (lr > h - 1) lr = h - 1;
      lc = col_out + cfg_r;
      if (lc > w - 1) lc = w - 1;
      return row_in * w + col_in > lr * w + lc;
   endfunction

   function automatic sample_type window_median(int rr, int rc);
      int         vals [49];
      int         n, y, x, v, j;
      n = 0;
      for (int dy = -int'(cfg_r); dy <= int'(cfg_r); dy++) begin
         for (int dx = -int'(cfg_r); dx <= int'(cfg_r); dx++) begin
            y = rr + dy;
            x = rc + dx;
            if (y >= 0 && y < int'(eff_height()) && x >= 0 && x < int'(eff_width())) begin
               vals[n] = rows[y % STORE_ROWS][x];
               n++;
            end
         end
      end
      if (n == 0) return '0;
      for (int i = 1; i < n; i++) begin
         v = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > v) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = v;
      end
      return sample_type'(vals[n / 2]);
   endfunction

   task automatic predict(req_type beat);
      int      limit, n;
      rsp_type r;
      limit = (beat.func == FUNC_DRAIN) ? 1 : 4;
      n = 0;
      if (beat.func == FUNC_SAMPLE && !full) begin
         rows[row_in % STORE_ROWS][col_in] = beat.sample;
         col_in++;
         if (col_in >= eff_width()) begin
            col_in = 0;
            row_in++;
            if (row_in >= eff_height()) begin
               row_in = 0;
               full = 1;
            end
         end
      end
      while (n < limit && window_complete()) begin
         r.median_value = window_median(row_out, col_out);
         r.out_col      = col_out[OUT_COL_BITS-1:0];
         r.out_row      = row_out[ROW_BITS-1:0];
         r.last_of_run  = 1'b0;
         medians_q = {medians_q, r};
         n++;
         col_out++;
         if (col_out >= eff_width()) begin
            col_out = 0;
            row_out++;
            if (row_out >= eff_height()) begin
               row_out = 0;
               full = 0;
            end
         end
      end
      if (n > 0) medians_q[medians_q.size() - 1].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         col_in = 0; row_in = 0; col_out = 0; row_out = 0; full = 0;
         cfg_w = 640; cfg_h = 480; cfg_r = 1;
         medians_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_WIDTH:  cfg_w = pwdata[CFG_W_BITS-1:0];
               REG_HEIGHT: cfg_h = pwdata[CFG_H_BITS-1:0];
               REG_RADIUS: cfg_r = pwdata[CFG_R_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (medians_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: %p", rsp_payload);
            end else begin
               want = medians_q.pop_front();
               if (rsp_payload.median_value !== want.median_value ||
                   rsp_payload.out_col !== want.out_col ||
                   rsp_payload.out_row !== want.out_row ||
                   rsp_payload.last_of_run !== want.last_of_run) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected %p, got %p", want, rsp_payload);
               end
            end
         end
      end
      pending    = medians_q.size();
      frame_open = full || col_in != 0 || row_in != 0 || col_out != 0 || row_out != 0;
   end

endmodule

/* sim/testbench.sv */
// testbench: drives frames, drain beats and register writes into the 2-D median filter
// with random idling on both channels; median_checker predicts and compares.
// Depends on mf2d_pkg, median_filter_2d_top, median_checker.
module testbench import mf2d_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          fail_count, pending;
   logic        frame_open;
   bit          no_idle;
   int          sample_beats;

   median_filter_2d_top i_dut (.*);
   median_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         rsp_stall = !no_idle && $urandom_range(99) < 14;
      end
   end

   initial begin
      #30ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_beat(logic func, sample_type value);
      while (!no_idle && $urandom_range(99) < 14) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_payload.func = func;
      req_payload.sample = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
      if (func == FUNC_SAMPLE) sample_beats++;
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      psel = 1; penable = 0; pwrite = 1; paddr = {index, 2'b00}; pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   task automatic wait_idle();
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3: return sample_type'($urandom_range(4) - 2);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // full frame, then drains until every pending pixel is out
   task automatic run_frame(int w, int h, int r, bit extra_samples);
      int beats;
      wait_idle();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RADIUS, r);
      if (w == 0) w = 1;
      if (w > 1024) w = 1024;
      if (h == 0) h = 1;
      beats = w * h;
      for (int i = 0; i < beats; i++) send_beat(FUNC_SAMPLE, pick_sample());
      // extra samples only while the frame is still held full, so they are ignored
      if (extra_samples) begin
         if (frame_open) send_beat(FUNC_SAMPLE, 16'sh7FFF);
         if (frame_open) send_beat(FUNC_SAMPLE, 16'sh8000);
      end
      while (frame_open) send_beat(FUNC_DRAIN, pick_sample());
   endtask

   initial begin
      reset = 1; req_valid = 0; req_payload = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      no_idle = 0; sample_beats = 0;
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);
      send_beat(FUNC_DRAIN, 16'sh0000);
      // directed: extremes, ignored samples after frame end
      wait_idle();
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 3);
      write_reg(REG_RADIUS, 1);
      send_beat(FUNC_SAMPLE, 16'sh8000);
      send_beat(FUNC_SAMPLE, 16'sh7FFF);
      send_beat(FUNC_SAMPLE, 16'sh0000);
      send_beat(FUNC_SAMPLE, 16'shFFFF);
      send_beat(FUNC_SAMPLE, 16'sh0001);
      send_beat(FUNC_SAMPLE, 16'sh5555);
      send_beat(FUNC_SAMPLE, 16'shAAAA);
      send_beat(FUNC_SAMPLE, 16'sh8000);
      send_beat(FUNC_SAMPLE, 16'sh7FFF);
      send_beat(FUNC_SAMPLE, 16'sh1234);
      while (frame_open) send_beat(FUNC_DRAIN, 16'sh0000);
      send_beat(FUNC_DRAIN, 16'sh0000);
      run_frame(0, 0, 3, 1);
      run_frame(2, 2, 0, 0);
      run_frame(4, 3, 2, 1);
      no_idle = 1;
      run_frame(24, 4, 3, 0);
      no_idle = 0;
      while (sample_beats < 450) begin
         if ($urandom_range(5) == 0)
            run_frame($urandom_range(40, 1), $urandom_range(4, 1), $urandom_range(3), 1);
         else
            run_frame($urandom_range(12, 1), $urandom_range(9, 1), $urandom_range(3),
                      1'($urandom_range(1)));
      end
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/mf2d_pkg.sv
hdl/mf2d_cell.sv
hdl/mf2d_sorter.sv
hdl/median_filter_2d_top.sv
sim/median_checker.sv
sim/testbench.sv
